// ----- rtl/fla_pkg.sv -----
`default_nettype none
package fla_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int ACTION_W = 2;
  localparam int IDX_W    = 11;
  localparam int GRANT_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/fla_link_ram.sv -----
`default_nettype none
module fla_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/fla_ctrl.sv -----
`default_nettype none
module fla_ctrl #(
  parameter int SLOTS = fla_pkg::SLOTS_DEF,
  parameter int AW    = 10,
  parameter int LW    = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fla_pkg::ACTION_W-1:0] in_action,
  input  wire logic [fla_pkg::IDX_W-1:0]    in_slot_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [fla_pkg::GRANT_W-1:0]  out_granted_index,
  output logic      [fla_pkg::STATUS_W-1:0] out_status,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [LW-1:0]                mem_wdata,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [LW-1:0]                mem_rdata
);
  import fla_pkg::*;

  localparam int CW = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [LW-1:0] END_MARK = LW'(SLOTS);
  localparam logic [AW-1:0] LAST     = AW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_ALLOC
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [GRANT_W-1:0]    grant_r, grant_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic accept;
  logic out_free;
  logic idx_bad;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign idx_bad  = CW'(in_slot_index) >= CW'(SLOTS);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && out_stall;
    grant_nxt     = grant_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = LW'(cnt_r) + LW'(1);
    mem_raddr     = head_r[AW-1:0];
    case (state_r)
      S_SWEEP: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
          head_nxt  = '0;
          if (pend_r) begin
            pend_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            grant_nxt     = '0;
            status_nxt    = ST_OK;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          grant_nxt  = '0;
          status_nxt = ST_OK;
          case (in_action)
            ACT_ALLOC: begin
              if (head_r >= END_MARK) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_EXHAUSTED;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            ACT_FREE: begin
              out_valid_nxt = 1'b1;
              if (idx_bad) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_slot_index);
                mem_wdata = head_r;
                head_nxt  = LW'(in_slot_index);
              end
            end
            ACT_CLEAR: begin
              state_nxt = S_SWEEP;
              cnt_nxt   = '0;
              pend_nxt  = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        state_nxt     = S_IDLE;
        head_nxt      = mem_rdata;
        out_valid_nxt = 1'b1;
        grant_nxt     = GRANT_W'(head_r);
        status_nxt    = ST_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    grant_r  <= grant_nxt;
    status_r <= status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = grant_r;
  assign out_status        = status_r;

endmodule
`default_nettype wire

// ----- rtl/free_list_slot_allocator_unit.sv -----
`default_nettype none
// Free-list slot allocator. Allocate passes through the S_ALLOC state (link of
// the head slot is read from the link RAM, which has a registered read, before
// the head moves); free, exhausted, out-of-range and unused action codes are
// answered from S_IDLE. Clear, and reset, run an init sweep that writes one
// link RAM entry per cycle, one per slot (SLOTS, 1024 by default), during which
// in_stall stays high; clear's result follows the sweep.
// One request is in flight at a time; in_stall also rises while a result is
// held by out_stall.
module free_list_slot_allocator_unit #(
  parameter int SLOTS = fla_pkg::SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fla_pkg::ACTION_W-1:0] in_action,
  input  wire logic [fla_pkg::IDX_W-1:0]    in_slot_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [fla_pkg::GRANT_W-1:0]  out_granted_index,
  output logic      [fla_pkg::STATUS_W-1:0] out_status
);
  import fla_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  fla_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .LW    (LW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  fla_link_ram #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .DW    (LW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/fla_checker.sv -----
`default_nettype none
module fla_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [fla_pkg::ACTION_W-1:0] in_action,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [fla_pkg::GRANT_W-1:0]  out_granted_index,
  input wire logic [fla_pkg::STATUS_W-1:0] out_status
);
  import fla_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_index) && $stable(out_status))
    else $error("stalled result changed");

  // no new request while a result is held
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result held");

  // allocate answers through the S_ALLOC state, or directly with exhausted status when the pool is empty
  a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACT_ALLOC |=>
      (out_valid && out_status == ST_EXHAUSTED) or (!out_valid ##1 out_valid))
    else $error("allocate latency wrong");

  // free answers next cycle with no grant
  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACT_FREE |=> out_valid && out_granted_index == '0 &&
      (out_status == ST_OK || out_status == ST_RANGE))
    else $error("free result wrong");

endmodule

bind free_list_slot_allocator_unit fla_checker u_fla_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_action         (in_action),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_granted_index (out_granted_index),
  .out_status        (out_status)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fla_pkg::*;

  localparam int POOL = SLOTS_DEF;
  localparam int MAX_IDX = (1 << IDX_W) - 1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 100;
  localparam int TAIL_CYCLES = 20;
  localparam int unsigned LIMIT = 1200000;

  typedef struct packed {
    logic [GRANT_W-1:0]  grant;
    logic [STATUS_W-1:0] status;
  } slot_result_t;

  // Free-list predictor plus the queue of results still owed by the block.
  class slot_pool_book;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] link [POOL];
    slot_result_t owed [$];
    int errors;

    function new();
      errors = 0;
      rebuild();
    endfunction

    function void rebuild();
      head = '0;
      foreach (link[i]) link[i] = IDX_W'(i + 1);
    endfunction

    function slot_result_t note_request(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx);
      slot_result_t r;
      r.grant = '0;
      r.status = ST_OK;
      case (act)
        ACT_ALLOC: begin
          if (head >= POOL) begin
            r.status = ST_EXHAUSTED;
          end else begin
            r.grant = head[GRANT_W-1:0];
            head = link[head];
          end
        end
        ACT_FREE: begin
          if (idx >= POOL) begin
            r.status = ST_RANGE;
          end else begin
            link[idx] = head;
            head = idx;
          end
        end
        ACT_CLEAR: rebuild();
        default: ;
      endcase
      owed.push_back(r);
      return r;
    endfunction

    function void check_result(logic [GRANT_W-1:0] grant, logic [STATUS_W-1:0] status);
      slot_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, granted %0d status %0d", $time, grant, status);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (grant !== e.grant) begin
        $display("%0t: granted_index expected %0d, got %0d", $time, e.grant, grant);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status expected %0d, got %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = ACT_ALLOC;
  logic [IDX_W-1:0]    in_slot_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [GRANT_W-1:0]  out_granted_index;
  logic [STATUS_W-1:0] out_status;

  slot_pool_book book = new();
  logic [IDX_W-1:0] held [$];
  bit calm = 1'b0;
  int stall_left = 0;
  int unsigned cycles = 0;

  free_list_slot_allocator_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_index(out_granted_index),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // alternate busy and quiet stretches
  initial begin
    forever begin
      repeat ($urandom_range(200, 1500)) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_granted_index, out_status);
  end

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] idx);
    int gap;
    slot_result_t r;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_slot_index <= idx;
    do @(posedge clk); while (in_stall);
    r = book.note_request(act, idx);
    if (act == ACT_ALLOC && r.status == ST_OK) held.push_back(IDX_W'(r.grant));
    if (act == ACT_CLEAR) held.delete();
  endtask

  task automatic free_held();
    int k;
    logic [IDX_W-1:0] s;
    k = $urandom_range(0, held.size() - 1);
    s = held[k];
    held.delete(k);
    send_request(ACT_FREE, s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.owed.size() != 0);
  endtask

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, IDX_W'(MAX_IDX));
    send_request(ACT_FREE, IDX_W'(POOL - 1));
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, IDX_W'(POOL));
    send_request(ACT_FREE, IDX_W'(MAX_IDX));
    send_request(ACT_FREE, '0);
    send_request(ACT_FREE, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_UNUSED, IDX_W'(MAX_IDX));
    send_request(ACT_UNUSED, '0);
    send_request(ACT_CLEAR, IDX_W'(MAX_IDX));
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, IDX_W'(1));
    send_request(ACT_ALLOC, '0);
    wait_drained();

    // allocate past the pool size with occasional frees, then free five held slots and allocate seven more
    send_request(ACT_CLEAR, '0);
    for (int i = 0; i < POOL + 4; i++) begin
      if ($urandom_range(0, 49) == 0 && held.size() > 0) free_held();
      send_request(ACT_ALLOC, '0);
    end
    repeat (5) free_held();
    repeat (7) send_request(ACT_ALLOC, IDX_W'($urandom_range(0, MAX_IDX)));
    send_request(ACT_CLEAR, IDX_W'($urandom_range(0, MAX_IDX)));
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38) send_request(ACT_ALLOC, IDX_W'($urandom_range(0, MAX_IDX)));
      else if (r < 68 && held.size() > 0) free_held();
      else if (r < 80) send_request(ACT_FREE, IDX_W'($urandom_range(0, POOL - 1)));
      else if (r < 90) send_request(ACT_FREE, IDX_W'($urandom_range(POOL, MAX_IDX)));
      else if (r < 95) send_request(ACT_UNUSED, IDX_W'($urandom_range(0, MAX_IDX)));
      else if (r < 97) send_request(ACT_CLEAR, IDX_W'($urandom_range(0, MAX_IDX)));
      else send_request(ACT_FREE, IDX_W'($urandom_range(0, MAX_IDX)));
      if ($urandom_range(0, 99) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
